// ----- rtl/hdf_pkg.sv -----
`default_nettype none

package hdf_pkg;

    // Bytes per dump line; must be a power of two so the column is a bit slice
    localparam int LINE_BYTES  = 16;
    localparam int COL_W       = $clog2(LINE_BYTES);
    localparam int OFFSET_W    = 32;
    localparam int ADDR_DIGITS = OFFSET_W / 4;
    localparam int NIB_W       = $clog2(ADDR_DIGITS);

    // Column of the last byte on a line
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_BYTES - 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte codes that end a dump
    localparam logic [7:0] END_CODE_EOT = 8'h04;
    localparam logic [7:0] END_CODE_DEL = 8'hFF;

    // Text characters
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

    // One queued command: a data byte at an offset, or a flush of a partial line
    typedef struct packed {
        logic                flush;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDR,
        ST_COLON,
        ST_SEP,
        ST_HI,
        ST_LO,
        ST_PAD_SEP,
        ST_PAD1,
        ST_PAD2,
        ST_GAP1,
        ST_GAP2,
        ST_TEXT,
        ST_CR,
        ST_LF
    } state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    endfunction

    function automatic logic [7:0] text_of(input logic [7:0] b);
        text_of = (b < CH_PRINT_LO || b > CH_PRINT_HI) ? CH_DOT : b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hdf_front.sv -----
`default_nettype none

module hdf_front
    import hdf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  wire q_stat_t    q_stat,
    output logic            push,
    output cmd_t            push_cmd
);

    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic                accept;
    logic                is_end;
    logic                col_zero;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign is_end   = s_tlast || (s_tdata == END_CODE_EOT) || (s_tdata == END_CODE_DEL);
    assign col_zero = (offset_reg[COL_W-1:0] == '0);

    // Drop an end at a line boundary: it only clears the offset
    assign push           = accept && !(is_end && col_zero);
    assign push_cmd.flush = is_end;
    assign push_cmd.offset = offset_reg;
    assign push_cmd.data  = s_tdata;

    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
        begin
            offset_next = is_end ? '0 : offset_reg + OFFSET_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (offset_reg == '0))
        else $error("offset not cleared after end");

endmodule

`default_nettype wire

// ----- rtl/hdf_queue.sv -----
`default_nettype none

module hdf_queue
    import hdf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output q_stat_t   q_stat
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/hdf_back.sv -----
`default_nettype none

module hdf_back
    import hdf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire q_stat_t    q_stat,
    input  wire cmd_t       pop_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    state_t              state_reg;
    state_t              state_next;
    logic                flush_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic [7:0]          byte_reg;
    logic [COL_W-1:0]    idx_reg;
    logic [COL_W-1:0]    idx_next;
    logic [NIB_W-1:0]    nib_reg;
    logic [NIB_W-1:0]    nib_next;
    logic [7:0]          line_mem [LINE_BYTES];

    logic                out_valid_reg;
    logic [7:0]          out_char_reg;
    logic                out_last_reg;

    logic [COL_W-1:0]    col;
    logic [COL_W-1:0]    text_last;
    logic                advance;
    logic [7:0]          emit_char;
    logic                emit_last;

    assign col       = off_reg[COL_W-1:0];
    // Text column of a flush covers the stored bytes only
    assign text_last = flush_reg ? (col - COL_W'(1)) : col;
    assign advance   = (state_reg != ST_IDLE) && (!out_valid_reg || m_tready);
    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        nib_next   = nib_reg;
        if (pop)
        begin
            idx_next = pop_cmd.offset[COL_W-1:0];
            nib_next = NIB_W'(ADDR_DIGITS - 1);
            if (pop_cmd.flush)
            begin
                state_next = pop_cmd.offset[0] ? ST_PAD1 : ST_PAD_SEP;
            end
            else if (pop_cmd.offset[COL_W-1:0] == '0)
            begin
                state_next = ST_ADDR;
            end
            else
            begin
                state_next = pop_cmd.offset[0] ? ST_HI : ST_SEP;
            end
        end
        else if (advance)
        begin
            unique case (state_reg)
                ST_ADDR:
                begin
                    if (nib_reg == '0)
                    begin
                        state_next = ST_COLON;
                    end
                    else
                    begin
                        nib_next = nib_reg - NIB_W'(1);
                    end
                end
                ST_COLON:   state_next = off_reg[0] ? ST_HI : ST_SEP;
                ST_SEP:     state_next = ST_HI;
                ST_HI:      state_next = ST_LO;
                ST_LO:      state_next = (col == LAST_COL) ? ST_GAP1 : ST_IDLE;
                ST_PAD_SEP: state_next = ST_PAD1;
                ST_PAD1:    state_next = ST_PAD2;
                ST_PAD2:
                begin
                    if (idx_reg == LAST_COL)
                    begin
                        state_next = ST_GAP1;
                    end
                    else
                    begin
                        idx_next   = idx_reg + COL_W'(1);
                        state_next = idx_reg[0] ? ST_PAD_SEP : ST_PAD1;
                    end
                end
                ST_GAP1:    state_next = ST_GAP2;
                ST_GAP2:
                begin
                    idx_next   = '0;
                    state_next = ST_TEXT;
                end
                ST_TEXT:
                begin
                    if (idx_reg == text_last)
                    begin
                        state_next = ST_CR;
                    end
                    else
                    begin
                        idx_next = idx_reg + COL_W'(1);
                    end
                end
                ST_CR:      state_next = ST_LF;
                ST_LF:      state_next = ST_IDLE;
                default:    state_next = ST_IDLE;
            endcase
        end
    end

    // Outputs: character of the current step and whether it ends the command
    always_comb
    begin
        emit_char = CH_SPACE;
        emit_last = 1'b0;
        unique case (state_reg)
            ST_ADDR:  emit_char = hex_char(off_reg[{nib_reg, 2'b00} +: 4]);
            ST_COLON: emit_char = CH_COLON;
            ST_HI:    emit_char = hex_char(byte_reg[7:4]);
            ST_LO:
            begin
                emit_char = hex_char(byte_reg[3:0]);
                emit_last = (col != LAST_COL);
            end
            ST_TEXT:  emit_char = text_of(line_mem[idx_reg]);
            ST_CR:    emit_char = CH_CR;
            ST_LF:
            begin
                emit_char = CH_LF;
                emit_last = 1'b1;
            end
            default:  emit_char = CH_SPACE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        nib_reg <= nib_next;
        if (pop)
        begin
            flush_reg <= pop_cmd.flush;
            off_reg   <= pop_cmd.offset;
            byte_reg  <= pop_cmd.data;
            if (!pop_cmd.flush)
            begin
                line_mem[pop_cmd.offset[COL_W-1:0]] <= pop_cmd.data;
            end
        end
        if (advance)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    a_addr_at_line_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADDR) |-> (col == '0 && !flush_reg))
        else $error("offset printed away from line start");

    a_flush_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && flush_reg) |-> (col != '0))
        else $error("flush of an empty line");

endmodule

`default_nettype wire

// ----- rtl/hex_dump_formatter_core.sv -----
`default_nettype none
// The first character of a transaction passes the queue entry, the back's command
// registers and the output register before it is valid. Output: one character per cycle
//   while the receiver is ready, with an idle load step per command; the back takes a new
//   command only when idle, and the two-entry queue lets the front accept meanwhile.
// Reset (rst_n low, asynchronous): offset cleared, queue and output emptied;
//   line store contents stay undefined until written.

module hex_dump_formatter_core
    import hdf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input byte stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_data
    // Output text stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic            m_tlast    // last_char
);

    q_stat_t q_stat;
    logic    push;
    cmd_t    push_cmd;
    logic    pop;
    cmd_t    pop_cmd;

    // Front: accept each transaction, classify data or end, track the offset
    hdf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Hold commands so the front keeps accepting while the back prints
    hdf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // Back: keep the line bytes and sequence the text one character per cycle while the receiver is ready
    hdf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench
    import hdf_pkg::*;
();

    // Cycles with no transaction on either side before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold below, plus latency.
    localparam int STALL_LIMIT      = 2000;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 60;

    // Predicts the dump text from the accepted bytes and holds it until the
    // block emits it. Each entry is {last_char, out_char}.
    class dump_text_scoreboard;
        logic [31:0] dump_offset;
        logic [7:0]  line_bytes [LINE_BYTES];
        logic [8:0]  expected_text [$];
        int          errors;

        function new();
            dump_offset = '0;
            errors      = 0;
        endfunction

        function logic [7:0] hex_digit(logic [3:0] nib);
            logic [7:0] n8;
            n8 = {4'h0, nib};
            return (n8 > 8'd9) ? (n8 - 8'd10 + "a") : (n8 + "0");
        endfunction

        // Two spaces, the first count stored bytes as text, then CR LF.
        function void add_text_column(ref logic [7:0] chars [$], input int count);
            chars.push_back(CH_SPACE);
            chars.push_back(CH_SPACE);
            for (int i = 0; i < count; i++)
            begin
                if (line_bytes[i] >= CH_PRINT_LO && line_bytes[i] <= CH_PRINT_HI)
                    chars.push_back(line_bytes[i]);
                else
                    chars.push_back(CH_DOT);
            end
            chars.push_back(CH_CR);
            chars.push_back(CH_LF);
        endfunction

        function void take_byte(logic [7:0] data, logic end_flag);
            logic [7:0] chars [$];
            int         col;
            bit         is_end;
            is_end = end_flag || data == END_CODE_EOT || data == END_CODE_DEL;
            col    = dump_offset % LINE_BYTES;
            if (is_end)
            begin
                // Pad a partial line out to full width, then flush its text.
                if (col != 0)
                begin
                    for (int i = col; i < LINE_BYTES; i++)
                    begin
                        if (i % 2 == 0)
                            chars.push_back(CH_SPACE);
                        chars.push_back(CH_SPACE);
                        chars.push_back(CH_SPACE);
                    end
                    add_text_column(chars, col);
                end
                dump_offset = '0;
            end
            else
            begin
                if (col == 0)
                begin
                    for (int s = 7; s >= 0; s--)
                        chars.push_back(hex_digit(dump_offset[4*s +: 4]));
                    chars.push_back(CH_COLON);
                end
                if (!dump_offset[0])
                    chars.push_back(CH_SPACE);
                chars.push_back(hex_digit(data[7:4]));
                chars.push_back(hex_digit(data[3:0]));
                line_bytes[col] = data;
                dump_offset     = dump_offset + 32'd1;
                if (dump_offset % LINE_BYTES == 0)
                    add_text_column(chars, LINE_BYTES);
            end
            foreach (chars[i])
                expected_text.push_back({i == chars.size() - 1, chars[i]});
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            logic [8:0] want;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected char: expected none, actual %h last %b",
                         $time, ch, last);
                errors++;
                return;
            end
            want = expected_text.pop_front();
            if (want[7:0] !== ch)
            begin
                $display("%0t: out_char mismatch: expected %h, actual %h",
                         $time, want[7:0], ch);
                errors++;
            end
            if (want[8] !== last)
            begin
                $display("%0t: last_char mismatch: expected %b, actual %b",
                         $time, want[8], last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    dump_text_scoreboard scoreboard = new();

    // Idle rates in percent, and a one-shot request for a long receiver hold
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    bit hold_req      = 1'b0;
    int items_sent    = 0;

    hex_dump_formatter_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sample both sides at the rising edge, where every signal still holds its
    // value from before the edge; the scoreboard sees transactions in order.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            scoreboard.take_byte(s_tdata, s_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_char(m_tdata, m_tlast);
    end

    // Receiver: stall at the current idle rate, or hold off entirely for a
    // long stretch when asked, so the block backs up into its input.
    initial
    begin : text_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = SINK_HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one byte; return at the edge where the transaction completes.
    // Gaps drop tvalid; the next call raises it again with fresh data.
    task automatic send_item(input logic [7:0] data, input logic end_flag);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= end_flag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop tvalid and hold the sender until every predicted char has arrived.
    // The first edge lets the input monitor note the final transaction.
    task automatic wait_for_text_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_text.size() != 0)
            @(posedge clk);
    endtask

    // One dump: len random bytes, then an end by tlast, EOT or DEL.
    // Random bytes may themselves be end codes, which breaks the line early.
    task automatic send_dump(input int len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), 1'b0);
        case ($urandom_range(2))
            0: send_item(8'($urandom_range(255)), 1'b1);
            1: send_item(END_CODE_EOT, 1'b0);
            default: send_item(END_CODE_DEL, 1'b0);
        endcase
    endtask

    task automatic run_dumps(input int src_pct, input int sink_pct, input int item_goal);
        int len;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        while (items_sent < item_goal)
        begin
            // Mostly short partial lines; some whole lines to end on a boundary
            if ($urandom_range(7) == 0)
                len = LINE_BYTES * $urandom_range(1, 3);
            else
                len = $urandom_range(0, 35);
            send_dump(len);
        end
    endtask

    initial
    begin : main
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ends on a line boundary print nothing
        send_item(END_CODE_DEL, 1'b0);
        send_item(8'h00, 1'b1);
        // Printable range edges, flushed by EOT at an odd column
        send_item(8'h00, 1'b0);
        send_item(8'h1F, 1'b0);
        send_item(8'h20, 1'b0);
        send_item(8'h7E, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(END_CODE_EOT, 1'b0);
        // High and printable bytes, flushed by tlast at an even column; data is ignored
        send_item(8'h80, 1'b0);
        send_item(8'hFE, 1'b0);
        send_item(8'h41, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'hAA, 1'b1);
        // One byte only: the widest pad, flushed by DEL
        send_item(8'h01, 1'b0);
        send_item(END_CODE_DEL, 1'b0);
        wait_for_text_drain();

        // Phase 1: hold the receiver off while a long dump keeps coming,
        // then random dumps with a slow receiver
        src_idle_pct  = 19;
        sink_idle_pct = 54;
        hold_req      = 1'b1;
        send_dump(48);
        run_dumps(19, 54, 110);
        wait_for_text_drain();

        // Phase 2: slow sender, mostly ready receiver
        run_dumps(54, 19, 200);
        wait_for_text_drain();

        // Phase 3: no idling; one long dump carries the offset past 0x100
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_dump(280);
        run_dumps(0, 0, 500);
        wait_for_text_drain();

        // Catch any stray chars the block might still emit
        repeat (TAIL_CYCLES) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.expected_text.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
